FILE: src/dmpc_pkg.sv
// dmpc_pkg: types and constants for the dual motor PWM controller.
// Used by dual_motor_pwm_controller. No dependencies.
`timescale 1ns / 1ps

package dmpc_pkg;

	localparam int NUM_MOTORS = 2;

	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_SET_MODE  = 3'd1;
	localparam logic [2:0] OP_SET_SPEED = 3'd2;
	localparam logic [2:0] OP_INC       = 3'd3;
	localparam logic [2:0] OP_DEC       = 3'd4;

	localparam logic [1:0] MODE_IDLE     = 2'd0;
	localparam logic [1:0] MODE_FORWARD  = 2'd1;
	localparam logic [1:0] MODE_BACKWARD = 2'd2;
	localparam logic [1:0] MODE_BRAKE    = 2'd3;

	localparam logic [7:0] SPEED_MAX   = 8'hFF;
	localparam logic [7:0] SPEED_RESET = 8'd127;

	typedef struct packed {
		logic [2:0] opcode;
		logic [1:0] motor_index;
		logic [1:0] drive_mode;
		logic [7:0] amount;
	} cmd_t;

	typedef struct packed {
		logic       pwm_a;
		logic       pwm_b;
		logic       dir_a_first;
		logic       dir_a_second;
		logic       dir_b_first;
		logic       dir_b_second;
		logic [7:0] reported_speed;
	} res_t;

endpackage

FILE: src/dual_motor_pwm_controller.sv
// dual_motor_pwm_controller: two-motor PWM and H-bridge direction control.
// Depends on dmpc_pkg (cmd_t, res_t, opcodes, modes).
//
//  channel | dir | handshake           | payload
//  cmd     | in  | cmd_valid/cmd_stall | dmpc_pkg::cmd_t
//  res     | out | res_valid/res_stall | dmpc_pkg::res_t
//
// One item per cycle while cmd_stall is low; its result appears in the cycle after acceptance.
// State is updated combinationally from the accepted item and the result
// lands in a single output register.
// cmd_stall is high only while a result is held and res_stall is high.
// arst_n clears all state to its reset values and empties the result register.
`timescale 1ns / 1ps

module dual_motor_pwm_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  dmpc_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output dmpc_pkg::res_t res
);

	logic [7:0] speed_q [dmpc_pkg::NUM_MOTORS];
	logic [1:0] mode_q  [dmpc_pkg::NUM_MOTORS];
	logic [7:0] duty_q  [dmpc_pkg::NUM_MOTORS];
	logic [3:0] dir_q;
	logic       pend_q;
	logic [7:0] cnt_q;

	logic [7:0] speed_d [dmpc_pkg::NUM_MOTORS];
	logic [1:0] mode_d  [dmpc_pkg::NUM_MOTORS];
	logic [7:0] duty_d  [dmpc_pkg::NUM_MOTORS];
	logic [3:0] dir_d;
	logic       pend_d;
	logic [7:0] cnt_d;

	logic           res_valid_q;
	dmpc_pkg::res_t res_q;
	dmpc_pkg::res_t res_d;

	logic       accept;
	logic       sel;
	logic       idx_ok;
	logic [7:0] cur;
	logic [7:0] base;
	logic [8:0] sum;

	assign cmd_stall = res_valid_q & res_stall;
	assign accept    = cmd_valid & ~cmd_stall;
	assign sel       = cmd.motor_index[0];
	assign idx_ok    = ~cmd.motor_index[1];
	assign cur       = speed_q[sel];
	assign sum       = {1'b0, cur} + {1'b0, cmd.amount};
	assign base      = (cmd.opcode == dmpc_pkg::OP_SET_SPEED) ? cmd.amount : cur;

	always_comb begin
		speed_d = speed_q;
		mode_d  = mode_q;
		duty_d  = duty_q;
		dir_d   = dir_q;
		pend_d  = pend_q;
		cnt_d   = cnt_q;
		case (cmd.opcode)
			dmpc_pkg::OP_TICK: begin
				if (cnt_q == 8'd0 && pend_q) begin
					duty_d = speed_q;
					pend_d = 1'b0;
				end
				cnt_d = cnt_q + 8'd1;
			end
			dmpc_pkg::OP_SET_MODE, dmpc_pkg::OP_SET_SPEED: begin
				if (idx_ok) begin
					mode_d[sel]  = cmd.drive_mode;
					speed_d[sel] = base;
					pend_d       = 1'b1;
					case (cmd.drive_mode)
						dmpc_pkg::MODE_IDLE: begin
							speed_d[sel] = 8'd0;
						end
						dmpc_pkg::MODE_FORWARD: begin
							if (sel) dir_d[3:2] = 2'b01;
							else     dir_d[1:0] = 2'b01;
						end
						dmpc_pkg::MODE_BACKWARD: begin
							if (sel) dir_d[3:2] = 2'b10;
							else     dir_d[1:0] = 2'b10;
						end
						default: begin
							if (sel) dir_d[3:2] = 2'b00;
							else     dir_d[1:0] = 2'b00;
							speed_d[sel] = dmpc_pkg::SPEED_MAX;
						end
					endcase
				end
			end
			dmpc_pkg::OP_INC: begin
				if (idx_ok) begin
					speed_d[sel] = sum[8] ? dmpc_pkg::SPEED_MAX : sum[7:0];
					pend_d       = 1'b1;
				end
			end
			dmpc_pkg::OP_DEC: begin
				if (idx_ok) begin
					speed_d[sel] = (cur < cmd.amount) ? 8'd0 : cur - cmd.amount;
					pend_d       = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_d.pwm_a          = cnt_q < duty_d[0];
		res_d.pwm_b          = cnt_q < duty_d[1];
		res_d.dir_a_first    = dir_d[0];
		res_d.dir_a_second   = dir_d[1];
		res_d.dir_b_first    = dir_d[2];
		res_d.dir_b_second   = dir_d[3];
		res_d.reported_speed = idx_ok ? speed_d[sel] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dmpc_pkg::NUM_MOTORS; i++) begin
				speed_q[i] <= dmpc_pkg::SPEED_RESET;
				mode_q[i]  <= dmpc_pkg::MODE_IDLE;
				duty_q[i]  <= dmpc_pkg::SPEED_RESET;
			end
			dir_q       <= 4'd0;
			pend_q      <= 1'b0;
			cnt_q       <= 8'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				speed_q <= speed_d;
				mode_q  <= mode_d;
				duty_q  <= duty_d;
				dir_q   <= dir_d;
				pend_q  <= pend_d;
				cnt_q   <= cnt_d;
			end
			if (!cmd_stall) begin
				res_valid_q <= cmd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.opcode == dmpc_pkg::OP_TICK |=> cnt_q == $past(cnt_q) + 8'd1)
		else $error("period counter did not advance on tick");

	a_cmd_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.opcode != dmpc_pkg::OP_TICK |=> $stable(cnt_q))
		else $error("period counter moved on a command");

	a_latch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.opcode == dmpc_pkg::OP_TICK && cnt_q == 8'd0 |=> !pend_q)
		else $error("pending update survived period start");

	a_res_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid)
		else $error("accepted item produced no result");

	a_brake: assert property (@(posedge clk) disable iff (!arst_n)
		accept && idx_ok && cmd.opcode == dmpc_pkg::OP_SET_MODE
		&& cmd.drive_mode == dmpc_pkg::MODE_BRAKE |=> res.reported_speed == dmpc_pkg::SPEED_MAX)
		else $error("brake did not report full speed");

endmodule
